@@ hw/rtl/hsa_pkg.sv @@
// Shared types and codes for the host register slot allocator.
// Command, access, status and register index codes, the item and result words,
// and the control word broadcast to the slot cells. No dependencies.
`default_nettype none

package hsa_pkg;

    // Command codes of an input word
    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FLUSH = 2'd1;
    localparam logic [1:0] CMD_EVICT = 2'd2;

    // Access modes
    localparam logic [1:0] AM_READ  = 2'd0;
    localparam logic [1:0] AM_WRITE = 2'd1;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_RANGE    = 2'd1;
    localparam logic [1:0] ST_NO_SLOT  = 2'd2;

    // Configuration register indexes
    localparam logic CFG_LOCKED_MASK = 1'b0;
    localparam logic CFG_GUEST_LIMIT = 1'b1;

    localparam int MASK_W  = 16;
    localparam int LIMIT_W = 7;

    localparam logic [MASK_W-1:0]  LOCKED_MASK_RST = 16'h8011;
    localparam logic [LIMIT_W-1:0] GUEST_LIMIT_RST = 7'd16;

    typedef struct packed {
        logic [1:0] cmd;
        logic [5:0] guest_reg;
        logic [1:0] access_mode;
        logic [3:0] slot_index;
    } item_t;

    typedef struct packed {
        logic [3:0] host_slot;
        logic       hit;
        logic       load_needed;
        logic       writeback;
        logic [3:0] writeback_slot;
        logic [5:0] writeback_guest;
        logic [1:0] status;
        logic       last;
    } result_t;

    // Operation broadcast to the cells; selected ops act on cells with sel set
    typedef enum logic [2:0] {
        CELL_NOP,
        CELL_AGE,
        CELL_FILL,
        CELL_DIRTY,
        CELL_CLEAR,
        CELL_CLEAR_ALL
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     writes;
    } cell_ctrl_t;

    typedef struct packed {
        logic used;
        logic dirty;
        logic match;
    } cell_flags_t;

endpackage

`default_nettype wire

@@ hw/rtl/hsa_cell.sv @@
// One slot cell: holds used, dirty, guest and age of one host slot.
// Passes the oldest-candidate search word to its neighbor every cycle. Uses hsa_pkg.
`default_nettype none

module hsa_cell #(
    parameter int AGE_BITS   = 8,
    parameter int GUEST_BITS = 6
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  hsa_pkg::cell_ctrl_t      ctrl,
    input  wire                      sel,
    input  wire                      locked,
    input  wire  [GUEST_BITS-1:0]    look_guest,
    input  wire                      carry_in_found,
    input  wire  [AGE_BITS-1:0]      carry_in_age,
    output logic                     carry_out_found,
    output logic [AGE_BITS-1:0]      carry_out_age,
    output hsa_pkg::cell_flags_t     flags,
    output logic [GUEST_BITS-1:0]    guest,
    output logic [AGE_BITS-1:0]      age
);
    import hsa_pkg::*;

    localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

    logic                  used_reg, used_next;
    logic                  dirty_reg, dirty_next;
    logic [GUEST_BITS-1:0] guest_reg, guest_next;
    logic [AGE_BITS-1:0]   age_reg, age_next;
    logic                  found_reg, found_next;
    logic [AGE_BITS-1:0]   best_reg, best_next;
    logic                  take;

    // Apply the broadcast operation to this slot
    always_comb
    begin
        used_next  = used_reg;
        dirty_next = dirty_reg;
        guest_next = guest_reg;
        age_next   = age_reg;
        unique case (ctrl.op)
            CELL_NOP:
            begin
            end
            CELL_AGE:
            begin
                if (used_reg && age_reg != AGE_MAX)
                    age_next = age_reg + 1'b1;
            end
            CELL_FILL:
            begin
                if (sel)
                begin
                    used_next  = 1'b1;
                    dirty_next = ctrl.writes;
                    guest_next = look_guest;
                    age_next   = '0;
                end
            end
            CELL_DIRTY:
            begin
                if (sel)
                    dirty_next = 1'b1;
            end
            CELL_CLEAR:
            begin
                if (sel)
                begin
                    used_next  = 1'b0;
                    dirty_next = 1'b0;
                    age_next   = '0;
                end
            end
            CELL_CLEAR_ALL:
            begin
                used_next  = 1'b0;
                dirty_next = 1'b0;
                age_next   = '0;
            end
            default:
            begin
            end
        endcase
    end

    // Replace the search word when this slot is an older unlocked candidate
    always_comb
    begin
        take       = used_reg && !locked && (!carry_in_found || age_reg > carry_in_age);
        found_next = take ? 1'b1 : carry_in_found;
        best_next  = take ? age_reg : carry_in_age;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= 1'b0;
            dirty_reg <= 1'b0;
            guest_reg <= '0;
            age_reg   <= '0;
            found_reg <= 1'b0;
            best_reg  <= '0;
        end
        else
        begin
            used_reg  <= used_next;
            dirty_reg <= dirty_next;
            guest_reg <= guest_next;
            age_reg   <= age_next;
            found_reg <= found_next;
            best_reg  <= best_next;
        end
    end

    assign carry_out_found = found_reg;
    assign carry_out_age   = best_reg;
    assign flags.used      = used_reg;
    assign flags.dirty     = dirty_reg;
    assign flags.match     = used_reg && (guest_reg == look_guest);
    assign guest           = guest_reg;
    assign age             = age_reg;

endmodule

`default_nettype wire

@@ hw/rtl/host_register_slot_allocator_unit.sv @@
// Top level of the host register slot allocator: sequencer, config registers
// and the row of hsa_cell slot cells. Uses hsa_pkg and hsa_cell.
//
// Usage: drive item and raise start; the word is taken at an edge where start
// is high and busy is low. busy stays high until the command is finished.
// Each result word appears on result for one cycle with result_valid high;
// the receiver must take it then, it cannot stall the block.
// Config writes (cfg_we, cfg_index, cfg_data) take effect at the next edge; the
// user must make them only while busy is low, as the block does not enforce it.
// Steps after the accepting edge:
//   allocate hit, range error, evict: decided in S_LOOK
//   allocate miss: S_LOOK ages the used slots, then S_PICK fills a free unlocked
//     slot or reports no unlocked slot, else S_SCAN replaces the oldest slot once
//     the search word has walked the cell row one cell per cycle
//   flush: S_LOOK clears all slots and gives the last word when nothing is written
//     back; otherwise S_FLUSH gives one writeback per cycle
// One command is in flight at a time; busy drops in the result cycle, so the
// next word can be taken right then.
// Reset clears every slot and loads locked_mask 0x8011 and guest_reg_limit 16.
`default_nettype none

module host_register_slot_allocator_unit #(
    parameter int SLOTS      = 16,
    parameter int AGE_BITS   = 8,
    parameter int GUEST_BITS = 6
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             start,
    input  hsa_pkg::item_t                  item,
    output logic                            busy,
    output logic                            result_valid,
    output hsa_pkg::result_t                result,
    input  wire                             cfg_we,
    input  wire                             cfg_index,
    input  wire  [hsa_pkg::MASK_W-1:0]      cfg_data
);
    import hsa_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CMP_W = (GUEST_BITS > LIMIT_W) ? GUEST_BITS : LIMIT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_PICK,
        S_SCAN,
        S_FLUSH
    } state_t;

    state_t                 state_reg, state_next;
    item_t                  item_reg, item_next;
    result_t                res_reg, res_next;
    logic                   res_valid_reg, res_valid_next;
    logic [SLOTS-1:0]       pend_reg, pend_next;
    logic [IDX_W-1:0]       count_reg, count_next;
    logic [MASK_W-1:0]      locked_mask_reg;
    logic [LIMIT_W-1:0]     guest_limit_reg;

    cell_ctrl_t             ctrl;
    logic [SLOTS-1:0]       sel_v;
    logic [SLOTS-1:0]       lock_v, used_v, dirty_v, match_v, pend_v;
    logic [SLOTS-1:0]       free_v, unlk_v, evict_v, win_v;
    logic [SLOTS-1:0]       free_oh, win_oh, flush_oh, match_oh;
    logic [GUEST_BITS-1:0]  guest_a [SLOTS];
    logic [AGE_BITS-1:0]    age_a [SLOTS];
    logic                   found_c [SLOTS+1];
    logic [AGE_BITS-1:0]    best_c [SLOTS+1];
    cell_flags_t            flags_a [SLOTS];

    logic [GUEST_BITS-1:0]  look_guest;
    logic                   writes, reads, range_ok, evict_ok;
    logic                   vic_dirty;
    logic [GUEST_BITS-1:0]  vic_guest, evict_guest, flush_guest;

    function automatic logic [IDX_W-1:0] oh_index(input logic [SLOTS-1:0] oh);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < SLOTS; i++)
            if (oh[i])
                idx = idx | IDX_W'(i);
        return idx;
    endfunction

    // Head of the search chain: no candidate yet
    assign found_c[0] = 1'b0;
    assign best_c[0]  = '0;

    // Row of slot cells
    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        if (i < MASK_W)
        begin : g_lk
            assign lock_v[i] = locked_mask_reg[i];
        end
        else
        begin : g_nolk
            assign lock_v[i] = 1'b0;
        end

        hsa_cell #(
            .AGE_BITS   (AGE_BITS),
            .GUEST_BITS (GUEST_BITS)
        ) u_cell (
            .clk             (clk),
            .rst_n           (rst_n),
            .ctrl            (ctrl),
            .sel             (sel_v[i]),
            .locked          (lock_v[i]),
            .look_guest      (look_guest),
            .carry_in_found  (found_c[i]),
            .carry_in_age    (best_c[i]),
            .carry_out_found (found_c[i+1]),
            .carry_out_age   (best_c[i+1]),
            .flags           (flags_a[i]),
            .guest           (guest_a[i]),
            .age             (age_a[i])
        );

        assign used_v[i]  = flags_a[i].used;
        assign dirty_v[i] = flags_a[i].dirty;
        assign match_v[i] = flags_a[i].match;
        assign pend_v[i]  = flags_a[i].used && flags_a[i].dirty && (guest_a[i] != '0);
        assign free_v[i]  = !flags_a[i].used && !lock_v[i];
        assign unlk_v[i]  = !lock_v[i];
        assign evict_v[i] = (32'(item_reg.slot_index) == i);
        assign win_v[i]   = found_c[SLOTS] && flags_a[i].used && !lock_v[i]
                            && (age_a[i] == best_c[SLOTS]);
    end

    // Decode the held word and isolate the lowest set bit of each pick vector
    always_comb
    begin
        look_guest = GUEST_BITS'(item_reg.guest_reg);
        writes     = item_reg.access_mode != AM_READ;
        reads      = item_reg.access_mode != AM_WRITE;
        range_ok   = CMP_W'(look_guest) < CMP_W'(guest_limit_reg);
        evict_ok   = 32'(item_reg.slot_index) < SLOTS;
        free_oh    = free_v & (~free_v + 1'b1);
        win_oh     = win_v & (~win_v + 1'b1);
        flush_oh   = pend_reg & (~pend_reg + 1'b1);
        match_oh   = match_v & (~match_v + 1'b1);
    end

    // Select victim, evicted and flushed slot contents
    always_comb
    begin
        vic_dirty   = 1'b0;
        vic_guest   = '0;
        evict_guest = '0;
        flush_guest = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (win_oh[i])
            begin
                vic_dirty = vic_dirty | dirty_v[i];
                vic_guest = vic_guest | guest_a[i];
            end
            if (evict_v[i])
                evict_guest = evict_guest | guest_a[i];
            if (flush_oh[i])
                flush_guest = flush_guest | guest_a[i];
        end
    end

    // Sequencer: next state, cell operation and result word
    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        pend_next      = pend_reg;
        count_next     = count_reg;
        res_next       = '0;
        res_valid_next = 1'b0;
        ctrl.op        = CELL_NOP;
        ctrl.writes    = writes;
        sel_v          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_next  = item;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                state_next = S_IDLE;
                unique case (item_reg.cmd)
                    CMD_ALLOC:
                    begin
                        res_valid_next = 1'b1;
                        if (!range_ok)
                            res_next.status = ST_RANGE;
                        else if (|match_v)
                        begin
                            res_next.host_slot = 4'(oh_index(match_oh));
                            res_next.hit       = 1'b1;
                            if (writes)
                            begin
                                ctrl.op = CELL_DIRTY;
                                sel_v   = match_oh;
                            end
                        end
                        else
                        begin
                            // Miss: age the used slots, pick next cycle
                            res_valid_next = 1'b0;
                            ctrl.op        = CELL_AGE;
                            state_next     = S_PICK;
                        end
                    end
                    CMD_FLUSH:
                    begin
                        ctrl.op = CELL_CLEAR_ALL;
                        if (pend_v == '0)
                        begin
                            res_valid_next = 1'b1;
                            res_next.last  = 1'b1;
                        end
                        else
                        begin
                            pend_next  = pend_v;
                            state_next = S_FLUSH;
                        end
                    end
                    CMD_EVICT:
                    begin
                        res_valid_next = 1'b1;
                        if (evict_ok)
                        begin
                            ctrl.op            = CELL_CLEAR;
                            sel_v              = evict_v;
                            res_next.host_slot = item_reg.slot_index;
                            if (|(evict_v & used_v))
                            begin
                                res_next.writeback       = 1'b1;
                                res_next.writeback_slot  = item_reg.slot_index;
                                res_next.writeback_guest = 6'(evict_guest);
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_PICK:
            begin
                if (|free_v)
                begin
                    ctrl.op                = CELL_FILL;
                    sel_v                  = free_oh;
                    res_valid_next         = 1'b1;
                    res_next.host_slot     = 4'(oh_index(free_oh));
                    res_next.load_needed   = reads;
                    state_next             = S_IDLE;
                end
                else if (unlk_v == '0)
                begin
                    res_valid_next  = 1'b1;
                    res_next.status = ST_NO_SLOT;
                    state_next      = S_IDLE;
                end
                else
                begin
                    count_next = IDX_W'(SLOTS - 1);
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // Search word has crossed the whole row when the count runs out
                if (count_reg == '0)
                begin
                    ctrl.op              = CELL_FILL;
                    sel_v                = win_oh;
                    res_valid_next       = 1'b1;
                    res_next.host_slot   = 4'(oh_index(win_oh));
                    res_next.load_needed = reads;
                    if (vic_dirty)
                    begin
                        res_next.writeback       = 1'b1;
                        res_next.writeback_slot  = 4'(oh_index(win_oh));
                        res_next.writeback_guest = 6'(vic_guest);
                    end
                    state_next = S_IDLE;
                end
                else
                    count_next = count_reg - 1'b1;
            end
            S_FLUSH:
            begin
                res_valid_next           = 1'b1;
                res_next.writeback       = 1'b1;
                res_next.writeback_slot  = 4'(oh_index(flush_oh));
                res_next.writeback_guest = 6'(flush_guest);
                pend_next                = pend_reg & ~flush_oh;
                if ((pend_reg & ~flush_oh) == '0)
                begin
                    res_next.last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, working registers and the result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            pend_reg      <= '0;
            count_reg     <= '0;
            item_reg      <= '0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            pend_reg      <= pend_next;
            count_reg     <= count_next;
            item_reg      <= item_next;
            res_reg       <= res_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            locked_mask_reg <= LOCKED_MASK_RST;
            guest_limit_reg <= GUEST_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LOCKED_MASK: locked_mask_reg <= cfg_data;
                CFG_GUEST_LIMIT: guest_limit_reg <= cfg_data[LIMIT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign busy         = state_reg != S_IDLE;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

`default_nettype wire

@@ tb/host_register_slot_allocator_unit_test.sv @@
`timescale 1ns / 100ps
// Self-checking bench for host_register_slot_allocator_unit: a directed table, then random
// phases under several lock masks and guest limits, checked against a slot map predictor.
// Depends on hsa_pkg and the allocator RTL.

module host_register_slot_allocator_unit_test;
    import hsa_pkg::*;

    localparam int SLOT_COUNT   = 16;
    localparam int AGE_MAX      = 255;
    localparam int DRAIN_CYCLES = SLOT_COUNT + 8;
    localparam int CYCLE_LIMIT  = 400000;

    // Command and access codes not named by the package
    localparam logic [1:0] CMD_NONE    = 2'd3;
    localparam logic [1:0] AM_BOTH     = 2'd2;
    localparam logic [1:0] AM_BOTH_ALT = 2'd3;

    // Random stimulus styles
    localparam int STYLE_MIXED = 0;
    localparam int STYLE_AGING = 1;

    typedef struct {
        bit          is_write;
        logic        cfg_sel;
        logic [15:0] cfg_val;
        item_t       word;
        bit          pinned;
        result_t     exp;
    } script_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    item_t       item;
    logic        busy;
    logic        result_valid;
    result_t     result;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;

    // Typed expectation riding along with the word on the input side
    bit          pin_valid;
    result_t     pin_result;

    // Predictor copy of the slot map and registers
    bit          map_used  [SLOT_COUNT];
    bit          map_dirty [SLOT_COUNT];
    logic [5:0]  map_guest [SLOT_COUNT];
    logic [7:0]  map_age   [SLOT_COUNT];
    logic [15:0] mirror_locked;
    logic [6:0]  mirror_limit;

    result_t     awaited_words[$];
    script_row_t script[$];
    bit          gaps_on;
    int          error_count;
    int          commands_accepted;
    int          flush_count;
    int          results_seen;
    int          reg_writes;
    int          cycle_count;

    host_register_slot_allocator_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .item         (item),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic item_t make_word(input logic [1:0] c, input logic [5:0] g,
                                        input logic [1:0] mode, input logic [3:0] s);
        item_t w;
        w.cmd         = c;
        w.guest_reg   = g;
        w.access_mode = mode;
        w.slot_index  = s;
        return w;
    endfunction

    function automatic result_t make_result(input logic [3:0] slot, input logic hit,
                                            input logic load, input logic wb,
                                            input logic [3:0] wb_slot, input logic [5:0] wb_guest,
                                            input logic [1:0] st, input logic fin);
        result_t r;
        r.host_slot       = slot;
        r.hit             = hit;
        r.load_needed     = load;
        r.writeback       = wb;
        r.writeback_slot  = wb_slot;
        r.writeback_guest = wb_guest;
        r.status          = st;
        r.last            = fin;
        return r;
    endfunction

    // Allocate: range check, associative hit, else age and pick a victim
    task automatic predict_allocate(input logic [5:0] g, input logic [1:0] mode);
        result_t r;
        int      pick;
        int      best;
        bit      writes;
        bit      reads;
        r      = '0;
        pick   = -1;
        best   = 0;
        writes = (mode != AM_READ);
        reads  = (mode != AM_WRITE);
        if ({1'b0, g} >= mirror_limit)
        begin
            r.status = ST_RANGE;
            awaited_words.push_back(r);
            return;
        end
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (map_used[i] && map_guest[i] == g)
            begin
                if (writes)
                    map_dirty[i] = 1'b1;
                r.host_slot = i[3:0];
                r.hit       = 1'b1;
                awaited_words.push_back(r);
                return;
            end
        end
        // Age every used slot, saturating
        for (int i = 0; i < SLOT_COUNT; i++)
            if (map_used[i] && int'(map_age[i]) < AGE_MAX)
                map_age[i] = map_age[i] + 8'd1;
        // First free unlocked slot, else the oldest unlocked one
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (mirror_locked[i])
                continue;
            if (!map_used[i])
            begin
                pick = i;
                break;
            end
            if (pick < 0 || int'(map_age[i]) > best)
            begin
                pick = i;
                best = int'(map_age[i]);
            end
        end
        if (pick < 0)
        begin
            r.status = ST_NO_SLOT;
            awaited_words.push_back(r);
            return;
        end
        r.host_slot   = pick[3:0];
        r.load_needed = reads;
        if (map_used[pick] && map_dirty[pick])
        begin
            r.writeback       = 1'b1;
            r.writeback_slot  = pick[3:0];
            r.writeback_guest = map_guest[pick];
        end
        awaited_words.push_back(r);
        map_used[pick]  = 1'b1;
        map_dirty[pick] = writes;
        map_guest[pick] = g;
        map_age[pick]   = '0;
    endtask

    // Flush: one writeback per dirty slot with a non-zero guest, then clear all
    task automatic predict_flush();
        result_t run[SLOT_COUNT];
        int      n;
        n = 0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (map_used[i] && map_dirty[i] && map_guest[i] != 6'd0)
            begin
                run[n] = make_result(4'd0, 1'b0, 1'b0, 1'b1, i[3:0], map_guest[i], ST_OK, 1'b0);
                n++;
            end
            map_used[i]  = 1'b0;
            map_dirty[i] = 1'b0;
            map_age[i]   = '0;
        end
        if (n == 0)
        begin
            awaited_words.push_back(make_result(4'd0, 1'b0, 1'b0, 1'b0, 4'd0, 6'd0, ST_OK,
                                                1'b1));
            return;
        end
        run[n-1].last = 1'b1;
        for (int k = 0; k < n; k++)
            awaited_words.push_back(run[k]);
    endtask

    // Evict: free the slot, writeback whenever it was used
    task automatic predict_evict(input logic [3:0] s);
        result_t r;
        r           = '0;
        r.host_slot = s;
        if (map_used[s])
        begin
            r.writeback       = 1'b1;
            r.writeback_slot  = s;
            r.writeback_guest = map_guest[s];
        end
        awaited_words.push_back(r);
        map_used[s]  = 1'b0;
        map_dirty[s] = 1'b0;
        map_age[s]   = '0;
    endtask

    task automatic predict_command(input item_t w);
        case (w.cmd)
            CMD_ALLOC: predict_allocate(w.guest_reg, w.access_mode);
            CMD_FLUSH:
            begin
                flush_count++;
                predict_flush();
            end
            CMD_EVICT: predict_evict(w.slot_index);
            default: ;
        endcase
    endtask

    task automatic report_field(input string field, input int want, input int got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        error_count++;
    endtask

    task automatic compare_result(input result_t want, input result_t got);
        if (got.host_slot !== want.host_slot)
            report_field("host_slot", want.host_slot, got.host_slot);
        if (got.hit !== want.hit)
            report_field("hit", want.hit, got.hit);
        if (got.load_needed !== want.load_needed)
            report_field("load_needed", want.load_needed, got.load_needed);
        if (got.writeback !== want.writeback)
            report_field("writeback", want.writeback, got.writeback);
        if (got.writeback_slot !== want.writeback_slot)
            report_field("writeback_slot", want.writeback_slot, got.writeback_slot);
        if (got.writeback_guest !== want.writeback_guest)
            report_field("writeback_guest", want.writeback_guest, got.writeback_guest);
        if (got.status !== want.status)
            report_field("status", want.status, got.status);
        if (got.last !== want.last)
            report_field("last", want.last, got.last);
    endtask

    // Check result words, then predict any word accepted at this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
            begin
                results_seen++;
                if (awaited_words.size() == 0)
                begin
                    $display("%0t: unexpected result word, expected none, actual %h",
                             $time, result);
                    error_count++;
                end
                else
                    compare_result(awaited_words.pop_front(), result);
            end
            if (start && !busy)
            begin
                if (item.cmd != CMD_NONE)
                    commands_accepted++;
                predict_command(item);
                if (pin_valid)
                begin
                    void'(awaited_words.pop_back());
                    awaited_words.push_back(pin_result);
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d words still awaited", $time, awaited_words.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Present a word and hold it until the block takes it
    task automatic send_word(input item_t w, input bit pinned, input result_t exp);
        start      <= 1'b1;
        item       <= w;
        pin_valid  <= pinned;
        pin_result <= exp;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Randomly drop start for a pause while gaps are on
    task automatic maybe_pause();
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    // Hold off until every awaited word is in and the block is quiet
    task automatic drain();
        start <= 1'b0;
        while (awaited_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic sel, input logic [15:0] val);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        reg_writes++;
        if (sel == CFG_LOCKED_MASK)
            mirror_locked = val;
        else
            mirror_limit = val[6:0];
    endtask

    task automatic add_word(input item_t w);
        script_row_t row;
        row          = '{default: '0};
        row.word     = w;
        script.push_back(row);
    endtask

    task automatic add_pinned(input item_t w, input result_t r);
        script_row_t row;
        row        = '{default: '0};
        row.word   = w;
        row.pinned = 1'b1;
        row.exp    = r;
        script.push_back(row);
    endtask

    task automatic add_write(input logic sel, input logic [15:0] val);
        script_row_t row;
        row          = '{default: '0};
        row.is_write = 1'b1;
        row.cfg_sel  = sel;
        row.cfg_val  = val;
        script.push_back(row);
    endtask

    function automatic item_t random_word(input int style);
        item_t w;
        int    roll;
        w    = item_t'($urandom());
        roll = $urandom_range(0, 99);
        if (style == STYLE_AGING)
        begin
            w.cmd       = CMD_ALLOC;
            w.guest_reg = 6'($urandom_range(32, 63));
            return w;
        end
        if (roll < 70)
        begin
            // Well-formed allocate, half of them from a small hot set
            w.cmd       = CMD_ALLOC;
            w.guest_reg = 6'($urandom_range(0, int'(mirror_limit) - 1));
            if ($urandom_range(0, 1) == 0)
                w.guest_reg = w.guest_reg & 6'd7;
        end
        else if (roll < 82)
            w.cmd = CMD_EVICT;
        else if (roll < 89)
            w.cmd = CMD_FLUSH;
        else if (roll < 96)
        begin
            // Out-of-range guest where the limit leaves room for one
            w.cmd = CMD_ALLOC;
            if (mirror_limit <= 7'd63)
                w.guest_reg = 6'($urandom_range(int'(mirror_limit), 63));
        end
        else
            w.cmd = CMD_NONE;
        return w;
    endfunction

    task automatic run_phase(input logic [15:0] mask, input logic [6:0] limit, input int count);
        write_reg(CFG_LOCKED_MASK, mask);
        write_reg(CFG_GUEST_LIMIT, {9'd0, limit});
        for (int k = 0; k < count; k++)
        begin
            maybe_pause();
            send_word(random_word(STYLE_MIXED), 1'b0, '0);
        end
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        start      <= 1'b0;
        item       <= '0;
        cfg_we     <= 1'b0;
        cfg_index  <= 1'b0;
        cfg_data   <= '0;
        pin_valid  <= 1'b0;
        pin_result <= '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            map_used[i]  = 1'b0;
            map_dirty[i] = 1'b0;
            map_guest[i] = '0;
            map_age[i]   = '0;
        end
        mirror_locked     = LOCKED_MASK_RST;
        mirror_limit      = GUEST_LIMIT_RST;
        gaps_on           = 1'b1;
        error_count       = 0;
        commands_accepted = 0;
        flush_count       = 0;
        results_seen      = 0;
        reg_writes        = 0;
        cycle_count       = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, starting from the reset registers
        add_pinned(make_word(CMD_ALLOC, 6'd0, AM_READ, 4'd0),
                   make_result(4'd1, 1'b0, 1'b1, 1'b0, 4'd0, 6'd0, ST_OK, 1'b0));
        add_pinned(make_word(CMD_ALLOC, 6'd0, AM_WRITE, 4'd0),
                   make_result(4'd1, 1'b1, 1'b0, 1'b0, 4'd0, 6'd0, ST_OK, 1'b0));
        add_pinned(make_word(CMD_ALLOC, 6'd63, AM_BOTH, 4'd15),
                   make_result(4'd0, 1'b0, 1'b0, 1'b0, 4'd0, 6'd0, ST_RANGE, 1'b0));
        add_pinned(make_word(CMD_ALLOC, 6'd16, AM_READ, 4'd0),
                   make_result(4'd0, 1'b0, 1'b0, 1'b0, 4'd0, 6'd0, ST_RANGE, 1'b0));
        add_pinned(make_word(CMD_ALLOC, 6'd15, AM_WRITE, 4'd0),
                   make_result(4'd2, 1'b0, 1'b0, 1'b0, 4'd0, 6'd0, ST_OK, 1'b0));
        add_pinned(make_word(CMD_ALLOC, 6'd5, AM_BOTH_ALT, 4'd0),
                   make_result(4'd3, 1'b0, 1'b1, 1'b0, 4'd0, 6'd0, ST_OK, 1'b0));
        add_pinned(make_word(CMD_ALLOC, 6'd9, AM_READ, 4'd0),
                   make_result(4'd5, 1'b0, 1'b1, 1'b0, 4'd0, 6'd0, ST_OK, 1'b0));
        add_pinned(make_word(CMD_EVICT, 6'd0, AM_READ, 4'd15),
                   make_result(4'd15, 1'b0, 1'b0, 1'b0, 4'd0, 6'd0, ST_OK, 1'b0));
        add_pinned(make_word(CMD_EVICT, 6'd0, AM_READ, 4'd2),
                   make_result(4'd2, 1'b0, 1'b0, 1'b1, 4'd2, 6'd15, ST_OK, 1'b0));
        add_word(make_word(CMD_NONE, 6'd33, AM_BOTH_ALT, 4'd9));
        add_word(make_word(CMD_ALLOC, 6'd0, AM_READ, 4'd0));
        // Dirty guest zero in slot 1 is skipped by the flush
        add_pinned(make_word(CMD_FLUSH, 6'd0, AM_READ, 4'd0),
                   make_result(4'd0, 1'b0, 1'b0, 1'b1, 4'd3, 6'd5, ST_OK, 1'b1));
        add_pinned(make_word(CMD_FLUSH, 6'd63, AM_BOTH_ALT, 4'd15),
                   make_result(4'd0, 1'b0, 1'b0, 1'b0, 4'd0, 6'd0, ST_OK, 1'b1));
        add_write(CFG_LOCKED_MASK, 16'hFFFF);
        add_pinned(make_word(CMD_ALLOC, 6'd1, AM_WRITE, 4'd0),
                   make_result(4'd0, 1'b0, 1'b0, 1'b0, 4'd0, 6'd0, ST_NO_SLOT, 1'b0));
        add_write(CFG_LOCKED_MASK, 16'hFFFE);
        add_write(CFG_GUEST_LIMIT, 16'd64);
        add_pinned(make_word(CMD_ALLOC, 6'd63, AM_WRITE, 4'd0),
                   make_result(4'd0, 1'b0, 1'b0, 1'b0, 4'd0, 6'd0, ST_OK, 1'b0));
        // Only slot 0 is open, so the dirty guest 63 is replaced
        add_pinned(make_word(CMD_ALLOC, 6'd20, AM_READ, 4'd0),
                   make_result(4'd0, 1'b0, 1'b1, 1'b1, 4'd0, 6'd63, ST_OK, 1'b0));
        add_write(CFG_LOCKED_MASK, 16'h0000);
        add_pinned(make_word(CMD_ALLOC, 6'd7, AM_BOTH, 4'd0),
                   make_result(4'd1, 1'b0, 1'b1, 1'b0, 4'd0, 6'd0, ST_OK, 1'b0));
        add_write(CFG_LOCKED_MASK, 16'hFFFF);
        // Hit on a locked slot still hits
        add_pinned(make_word(CMD_ALLOC, 6'd7, AM_READ, 4'd0),
                   make_result(4'd1, 1'b1, 1'b0, 1'b0, 4'd0, 6'd0, ST_OK, 1'b0));
        add_pinned(make_word(CMD_EVICT, 6'd0, AM_READ, 4'd0),
                   make_result(4'd0, 1'b0, 1'b0, 1'b1, 4'd0, 6'd20, ST_OK, 1'b0));
        add_write(CFG_GUEST_LIMIT, 16'd1);
        add_pinned(make_word(CMD_ALLOC, 6'd1, AM_READ, 4'd0),
                   make_result(4'd0, 1'b0, 1'b0, 1'b0, 4'd0, 6'd0, ST_RANGE, 1'b0));
        add_word(make_word(CMD_ALLOC, 6'd0, AM_READ, 4'd0));

        foreach (script[k])
        begin
            if (script[k].is_write)
                write_reg(script[k].cfg_sel, script[k].cfg_val);
            else
            begin
                maybe_pause();
                send_word(script[k].word, script[k].pinned, script[k].exp);
            end
        end

        // Random phases over a spread of lock masks and guest limits
        run_phase(16'h0000, 7'd64, 50);
        run_phase(LOCKED_MASK_RST, GUEST_LIMIT_RST, 40);
        run_phase(16'($urandom_range(0, 65535)), 7'($urandom_range(1, 64)), 40);
        run_phase(16'($urandom_range(0, 65535)), 7'($urandom_range(1, 64)), 40);

        // Last stretch back to back
        gaps_on = 1'b0;
        run_phase(16'h0000, 7'd64, 50);
        drain();

        $display("Covered %0d commands (%0d flushes) and %0d result words over %0d writes",
                 commands_accepted, flush_count, results_seen, reg_writes);
        $display("of the lock mask and guest limit, ending with a gapless stretch.");
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
